// ===== sv/mtrp_pkg.sv =====
// Package with the byte codes, capture phase type and result type of the timestamp receive parser.
`timescale 1ns / 1ps

package mtrp_pkg;

	localparam logic [7:0] SUB_XOFF_CODE = 8'hF9;
	localparam logic [7:0] SUB_XON_CODE  = 8'hFD;
	localparam logic [7:0] XOFF_CODE     = 8'd19;
	localparam logic [7:0] XON_CODE      = 8'd17;
	localparam logic [7:0] SENSE_CODE    = 8'hFE;
	localparam logic [7:0] STAMP_CODE    = 8'hF5;
	localparam logic [7:0] CLKRST_CODE   = 8'hF4;

	localparam int unsigned RESTORE_MID_BIT = 6;
	localparam int unsigned RESTORE_LOW_BIT = 5;
	localparam int unsigned HIGH_TICK_BITS  = 5;
	localparam int unsigned TICK_W          = 16 + HIGH_TICK_BITS;
	localparam int unsigned CLICK_W         = 4;
	localparam int unsigned TIME_W          = 25;

	localparam logic [CLICK_W-1:0] CLICK_RESET = 4'd5;

	localparam logic KIND_MIDI  = 1'b0;
	localparam logic KIND_STAMP = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LOW,
		PH_MID,
		PH_HIGH
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [7:0]        midi_byte;
		logic [TIME_W-1:0] time_ms;
	} result_t;

endpackage

// ===== sv/mtrp_core.sv =====
// Capture state machine and decode of one registered byte into an optional result.
`timescale 1ns / 1ps

module mtrp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_take,
	input  logic [7:0]                    rx_byte_s1,
	input  logic [mtrp_pkg::CLICK_W-1:0]  click_ms,
	output mtrp_pkg::result_t             res
);

	mtrp_pkg::phase_t phase_q, phase_d;
	logic             is_stamp_q, is_stamp_d;
	logic [7:0]       low_byte_q, low_byte_d;
	logic [7:0]       mid_byte_q, mid_byte_d;
	logic [7:0]       mapped;
	logic [7:0]       b0, b1;
	logic [mtrp_pkg::TICK_W-1:0] ticks;
	logic [mtrp_pkg::TIME_W-1:0] product;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mtrp_pkg::PH_IDLE;
			is_stamp_q <= 1'b0;
			low_byte_q <= 8'd0;
			mid_byte_q <= 8'd0;
		end else begin
			phase_q    <= phase_d;
			is_stamp_q <= is_stamp_d;
			low_byte_q <= low_byte_d;
			mid_byte_q <= mid_byte_d;
		end
	end

	always_comb begin
		if (rx_byte_s1 == mtrp_pkg::SUB_XOFF_CODE) begin
			mapped = mtrp_pkg::XOFF_CODE;
		end else if (rx_byte_s1 == mtrp_pkg::SUB_XON_CODE) begin
			mapped = mtrp_pkg::XON_CODE;
		end else begin
			mapped = rx_byte_s1;
		end
	end

	always_comb begin
		b0 = low_byte_q | {mapped[mtrp_pkg::RESTORE_LOW_BIT], 7'd0};
		b1 = mid_byte_q | {mapped[mtrp_pkg::RESTORE_MID_BIT], 7'd0};
		ticks = {mapped[mtrp_pkg::HIGH_TICK_BITS-1:0], b1, b0};
		product = mtrp_pkg::TIME_W'(ticks) * mtrp_pkg::TIME_W'(click_ms);
	end

	always_comb begin
		phase_d       = phase_q;
		is_stamp_d    = is_stamp_q;
		low_byte_d    = low_byte_q;
		mid_byte_d    = mid_byte_q;
		res.valid     = 1'b0;
		res.kind      = mtrp_pkg::KIND_MIDI;
		res.midi_byte = 8'd0;
		res.time_ms   = '0;
		if (byte_take && (mapped != mtrp_pkg::SENSE_CODE)) begin
			unique case (phase_q)
				mtrp_pkg::PH_IDLE: begin
					if ((mapped == mtrp_pkg::STAMP_CODE) || (mapped == mtrp_pkg::CLKRST_CODE)) begin
						is_stamp_d = (mapped == mtrp_pkg::STAMP_CODE);
						phase_d    = mtrp_pkg::PH_LOW;
					end else begin
						res.valid     = 1'b1;
						res.midi_byte = mapped;
					end
				end
				mtrp_pkg::PH_LOW: begin
					low_byte_d = mapped;
					phase_d    = mtrp_pkg::PH_MID;
				end
				mtrp_pkg::PH_MID: begin
					mid_byte_d = mapped;
					phase_d    = mtrp_pkg::PH_HIGH;
				end
				mtrp_pkg::PH_HIGH: begin
					phase_d = mtrp_pkg::PH_IDLE;
					if (is_stamp_q) begin
						res.valid   = 1'b1;
						res.kind    = mtrp_pkg::KIND_STAMP;
						res.time_ms = product;
					end
				end
				default: begin
					phase_d = mtrp_pkg::PH_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/midi_timestamp_rx_parser_top.sv =====
// Top level of the serial MIDI receive parser with timestamp decode.
//
//  Channel   Handshake            Payload
//  in        in_valid, in_stall   rx_byte[7:0]
//  out       out_valid, out_stall kind, midi_byte[7:0], time_ms[24:0]
//  config    cfg_wr_en            cfg_wr_data[3:0] (click_ms)
//
// A byte is registered when accepted and decoded from that register into the output register,
// so one byte is taken every cycle while the output is not stalled.
// The input register is the only buffer in front of the output register; in_stall rises
// only while both hold a transaction and the output is stalled.
// Reset clears the capture state and sets click_ms to five milliseconds.
`timescale 1ns / 1ps

module midi_timestamp_rx_parser_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mtrp_pkg::CLICK_W-1:0]       cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         rx_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kind,
	output logic [7:0]                         midi_byte,
	output logic [mtrp_pkg::TIME_W-1:0]        time_ms
);

	logic [mtrp_pkg::CLICK_W-1:0] click_ms_q;
	logic                         valid_s1;
	logic [7:0]                   rx_byte_s1;
	logic                         out_valid_q;
	logic                         kind_q;
	logic [7:0]                   midi_byte_q;
	logic [mtrp_pkg::TIME_W-1:0]  time_ms_q;
	logic                         advance;
	logic                         in_take;
	mtrp_pkg::result_t            res;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_ms_q <= mtrp_pkg::CLICK_RESET;
		end else if (cfg_wr_en) begin
			click_ms_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	mtrp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_take  (valid_s1 && advance),
		.rx_byte_s1 (rx_byte_s1),
		.click_ms   (click_ms_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q      <= res.kind;
			midi_byte_q <= res.midi_byte;
			time_ms_q   <= res.time_ms;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign midi_byte = midi_byte_q;
	assign time_ms   = time_ms_q;

endmodule

// ===== sv/mtrp_checker.sv =====
// Port-level assertions for the timestamp receive parser and the bind that attaches them.
`timescale 1ns / 1ps

module mtrp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         kind,
	input logic [7:0]                   midi_byte,
	input logic [mtrp_pkg::TIME_W-1:0]  time_ms
);

	// A timestamp transaction carries no MIDI byte.
	a_stamp_clear_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == mtrp_pkg::KIND_STAMP)) |-> (midi_byte == 8'd0))
		else $error("timestamp result with nonzero midi_byte");

	// A MIDI byte transaction carries no time.
	a_midi_clear_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == mtrp_pkg::KIND_MIDI)) |-> (time_ms == '0))
		else $error("MIDI result with nonzero time_ms");

	// The input is held back only while the output side is full and stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output");

	// A stalled result stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(midi_byte)
			&& $stable(time_ms)))
		else $error("stalled result changed");

endmodule

bind midi_timestamp_rx_parser_top mtrp_checker u_mtrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.midi_byte (midi_byte),
	.time_ms   (time_ms)
);

// ===== tb/sv/midi_timestamp_rx_parser_top_test.sv =====
// Self-checking testbench for the timestamp receive parser, with directed and random traffic.
`timescale 1ns / 1ps

module midi_timestamp_rx_parser_top_test;

	import mtrp_pkg::*;

	typedef struct packed {
		logic              kind;
		logic [7:0]        midi_byte;
		logic [TIME_W-1:0] time_ms;
	} rx_result_t;

	typedef struct packed {
		logic [7:0]        rx;
		logic              typed;
		logic              has_res;
		logic              kind;
		logic [7:0]        midi_byte;
		logic [TIME_W-1:0] time_ms;
	} stim_row_t;

	localparam int unsigned N_ROWS = 25;
	localparam int unsigned N_PHASES = 6;
	localparam int unsigned ITEMS_PER_PHASE = 175;
	localparam logic [CLICK_W-1:0] CLICK_MAX = 4'd15;
	localparam logic [TIME_W-1:0] MAX_STAMP_AT_RESET = 25'd10485755;

	// Rows that are not typed are checked against the decoder model below.
	localparam stim_row_t STIM_ROWS [N_ROWS] = '{
		'{8'h00,         1'b1, 1'b1, KIND_MIDI,  8'h00,     25'd0},
		'{8'hFF,         1'b1, 1'b1, KIND_MIDI,  8'hFF,     25'd0},
		'{8'h7F,         1'b1, 1'b1, KIND_MIDI,  8'h7F,     25'd0},
		'{SUB_XOFF_CODE, 1'b1, 1'b1, KIND_MIDI,  XOFF_CODE, 25'd0},
		'{SUB_XON_CODE,  1'b1, 1'b1, KIND_MIDI,  XON_CODE,  25'd0},
		'{SENSE_CODE,    1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{XOFF_CODE,     1'b0, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{STAMP_CODE,    1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'h00,         1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'h00,         1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'h00,         1'b1, 1'b1, KIND_STAMP, 8'h00,     25'd0},
		'{STAMP_CODE,    1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'hFF,         1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'hFF,         1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'hFF,         1'b1, 1'b1, KIND_STAMP, 8'h00,     MAX_STAMP_AT_RESET},
		'{CLKRST_CODE,   1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'h55,         1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'hAA,         1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'h7F,         1'b1, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{STAMP_CODE,    1'b0, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{SUB_XOFF_CODE, 1'b0, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{SENSE_CODE,    1'b0, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{CLKRST_CODE,   1'b0, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'h60,         1'b0, 1'b0, KIND_MIDI,  8'h00,     25'd0},
		'{8'hF0,         1'b0, 1'b0, KIND_MIDI,  8'h00,     25'd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CLICK_W-1:0]   cfg_wr_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic                 kind;
	logic [7:0]           midi_byte;
	logic [TIME_W-1:0]    time_ms;

	phase_t               cap_phase = PH_IDLE;
	logic                 cap_stamp = 1'b0;
	logic [7:0]           cap_low = 8'h00;
	logic [7:0]           cap_mid = 8'h00;
	logic [CLICK_W-1:0]   click_len = CLICK_RESET;

	rx_result_t           pending_results [$];
	int unsigned          n_mismatch = 0;
	int unsigned          bytes_sent = 0;
	int unsigned          steady_left = 0;
	int unsigned          stall_left = 0;
	logic                 stall_now = 1'b0;

	midi_timestamp_rx_parser_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.midi_byte   (midi_byte),
		.time_ms     (time_ms)
	);

	always #2 clk = ~clk;

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advances the parser state by one byte and reports whether a result follows.
	function automatic bit decode_rx(input logic [7:0] raw, output rx_result_t res);
		logic [7:0]        c;
		logic [7:0]        lo;
		logic [7:0]        mid;
		logic [TIME_W-1:0] ticks;
		res = '0;
		c = raw;
		if (c == SUB_XOFF_CODE)
			c = XOFF_CODE;
		else if (c == SUB_XON_CODE)
			c = XON_CODE;
		if (c == SENSE_CODE)
			return 1'b0;
		case (cap_phase)
			PH_IDLE: begin
				if (c == STAMP_CODE || c == CLKRST_CODE) begin
					cap_stamp = (c == STAMP_CODE);
					cap_phase = PH_LOW;
					return 1'b0;
				end
				res.kind = KIND_MIDI;
				res.midi_byte = c;
				return 1'b1;
			end
			PH_LOW: begin
				cap_low = c;
				cap_phase = PH_MID;
				return 1'b0;
			end
			PH_MID: begin
				cap_mid = c;
				cap_phase = PH_HIGH;
				return 1'b0;
			end
			default: begin
				cap_phase = PH_IDLE;
				lo = cap_low | (c[RESTORE_LOW_BIT] ? 8'h80 : 8'h00);
				mid = cap_mid | (c[RESTORE_MID_BIT] ? 8'h80 : 8'h00);
				ticks = TIME_W'({c[HIGH_TICK_BITS-1:0], mid, lo});
				if (!cap_stamp)
					return 1'b0;
				res.kind = KIND_STAMP;
				res.time_ms = ticks * TIME_W'(click_len);
				return 1'b1;
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed, input bit typed_has,
			input rx_result_t typed_res);
		int unsigned gap;
		rx_result_t res;
		bit has;
		@(negedge clk);
		if (steady_left > 0) begin
			gap = 0;
			steady_left--;
		end else begin
			gap = gap_len();
			if ($urandom_range(0, 39) == 0)
				steady_left = $urandom_range(30, 80);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		has = decode_rx(b, res);
		if (typed) begin
			has = typed_has;
			res = typed_res;
		end
		if (has)
			pending_results.push_back(res);
		if (b != SENSE_CODE)
			bytes_sent++;
	endtask

	task automatic send_random(input logic [7:0] b);
		send_byte(b, 1'b0, 1'b0, '0);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_click(input logic [CLICK_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		click_len = v;
	endtask

	task automatic random_traffic(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned r;
		stop_at = bytes_sent + n_items;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_random(($urandom_range(0, 3) == 0) ? CLKRST_CODE : STAMP_CODE);
				repeat (3) begin
					if ($urandom_range(0, 15) == 0)
						send_random(SENSE_CODE);
					send_random(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, 127)));
				end
			end else if (r < 95) begin
				send_random(8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 2))
					0: send_random(SENSE_CODE);
					1: send_random(SUB_XOFF_CODE);
					default: send_random(SUB_XON_CODE);
				endcase
			end
		end
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_now = !stall_now;
			if (stall_now)
				stall_left = gap_len() + 1;
			else
				stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 20);
		end
		stall_left--;
		out_stall <= stall_now;
	end

	always @(posedge clk) begin
		rx_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d, midi_byte 0x%02h, time_ms %0d",
					kind, midi_byte, time_ms);
				n_mismatch++;
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					n_mismatch++;
				end
				if (midi_byte !== want.midi_byte) begin
					$error("midi_byte: expected 0x%02h, got 0x%02h", want.midi_byte, midi_byte);
					n_mismatch++;
				end
				if (time_ms !== want.time_ms) begin
					$error("time_ms: expected %0d, got %0d", want.time_ms, time_ms);
					n_mismatch++;
				end
			end
		end
	end

	initial begin
		logic [CLICK_W-1:0] phase_clicks [N_PHASES];
		rx_result_t row_res;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		phase_clicks = '{CLICK_MAX, 4'd1, 4'd0, 4'($urandom_range(2, 14)),
			4'($urandom_range(0, 15)), CLICK_RESET};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_ROWS; i++) begin
			row_res.kind = STIM_ROWS[i].kind;
			row_res.midi_byte = STIM_ROWS[i].midi_byte;
			row_res.time_ms = STIM_ROWS[i].time_ms;
			send_byte(STIM_ROWS[i].rx, STIM_ROWS[i].typed, STIM_ROWS[i].has_res, row_res);
		end
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			set_click(phase_clicks[p]);
			random_traffic(ITEMS_PER_PHASE);
			drain();
		end

		if (n_mismatch == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("Verification failed");
		$finish;
	end

endmodule
